/* sv/skt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants of the sorted key table
// Command codes, transaction structs, sequencer states and compare flags.
// ----------------------------------------------------------------------------
package skt_pkg;

   // field widths fixed by the transaction format
   localparam int DATA_W = 64;
   localparam int SLOT_W = 4;
   localparam int HELD_W = 5;

   // default sizing of the table
   localparam int CAPACITY_DEF  = 16;
   localparam int KEY_BYTES_DEF = 8;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_VERIFY = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [DATA_W-1:0]   user_key;
      logic [DATA_W-1:0]   user_secret;
   } req_type;

   typedef struct packed {
      logic                ok;
      logic [SLOT_W-1:0]   slot_index;
      logic [DATA_W-1:0]   stored_secret;
      logic [HELD_W-1:0]   entries_held;
      logic                changed;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_BS_RD,
      ST_BS_CMP,
      ST_INS_SCAN,
      ST_INS_SHIFT,
      ST_REM_SHIFT,
      ST_RESP
   } state_type;

   // flags from the shared comparator
   typedef struct packed {
      logic lt;
      logic eq;
      logic sec_eq;
   } cmp_res_type;

endpackage

/* sv/skt_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_mem: entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module skt_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/skt_cmp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_cmp: shared key and secret comparator
// Compares the entry just read against the key and secret of the command.
// ----------------------------------------------------------------------------
module skt_cmp #(
   parameter int KEY_W = 64
) (
   input  logic [KEY_W-1:0]          ent_key,
   input  logic [skt_pkg::DATA_W-1:0] ent_secret,
   input  logic [KEY_W-1:0]          ref_key,
   input  logic [skt_pkg::DATA_W-1:0] ref_secret,
   output skt_pkg::cmp_res_type      res
);
   import skt_pkg::*;

   // unsigned key order and secret match
   always_comb begin
      res.lt     = ent_key < ref_key;
      res.eq     = ent_key == ref_key;
      res.sec_eq = ent_secret == ref_secret;
   end

endmodule

/* sv/skt_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_seq: command sequencer
// Runs scans, halving searches and entry shifts over the entry memory.
// ----------------------------------------------------------------------------
module skt_seq #(
   parameter int CAPACITY  = 16,
   parameter int KEY_BYTES = 8
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           ordered_mode,
   input  logic                                           start,
   output logic                                           busy,
   input  skt_pkg::req_type                               req_data,
   output logic                                           rd_en,
   output logic [$clog2(CAPACITY)-1:0]                    rd_addr,
   input  logic [KEY_BYTES*8+skt_pkg::DATA_W-1:0]         rd_data,
   output logic                                           wr_en,
   output logic [$clog2(CAPACITY)-1:0]                    wr_addr,
   output logic [KEY_BYTES*8+skt_pkg::DATA_W-1:0]         wr_data,
   input  skt_pkg::cmp_res_type                           cmp,
   output logic [KEY_BYTES*8-1:0]                         ref_key,
   output logic [skt_pkg::DATA_W-1:0]                     ref_secret,
   output logic                                           rsp_strobe,
   output skt_pkg::rsp_type                               rsp_data
);
   import skt_pkg::*;

   localparam int KEY_W = KEY_BYTES * 8;
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [DATA_W-1:0] sec_ff, sec_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  lo_ff, lo_in;
   logic [CNT_W-1:0]  hi_ff, hi_in;
   logic [IDX_W-1:0]  mid_ff, mid_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic              pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0]  pend_addr_ff, pend_addr_in;
   logic              ok_ff, ok_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [DATA_W-1:0] rsec_ff, rsec_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              changed_ff, changed_in;

   logic              up_issue;
   logic              dn_issue;
   logic              up_end;
   logic              dn_end;
   logic              full;
   logic              hit;
   logic [IDX_W-1:0]  hit_idx;
   logic [CNT_W:0]    mid_sum;
   logic [IDX_W-1:0]  mid_calc;

   // pipeline and search status
   always_comb begin
      up_issue = ptr_ff < count_ff;
      dn_issue = ptr_ff > pos_ff;
      up_end   = !pend_vld_ff && !up_issue;
      dn_end   = !pend_vld_ff && !dn_issue;
      full     = count_ff == CNT_W'(CAPACITY);
      hit      = ((state_ff == ST_SCAN) && pend_vld_ff && cmp.eq) ||
                 ((state_ff == ST_BS_CMP) && cmp.eq);
      hit_idx  = (state_ff == ST_SCAN) ? pend_addr_ff : mid_ff;
      mid_sum  = (CNT_W+1)'(lo_ff) + (CNT_W+1)'(hi_ff) - (CNT_W+1)'(1);
      mid_calc = mid_sum[IDX_W:1];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_data.cmd == CMD_INSERT) begin
                  if (full) begin
                     state_in = ST_RESP;
                  end else if (ordered_mode) begin
                     state_in = ST_INS_SCAN;
                  end else begin
                     state_in = ST_INS_SHIFT;
                  end
               end else if (ordered_mode) begin
                  state_in = ST_BS_RD;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = (cmd_ff == CMD_REMOVE) ? ST_REM_SHIFT : ST_RESP;
            end else if (up_end) begin
               state_in = ST_RESP;
            end
         end
         ST_BS_RD: begin
            state_in = (lo_ff < hi_ff) ? ST_BS_CMP : ST_RESP;
         end
         ST_BS_CMP: begin
            if (hit) begin
               state_in = (cmd_ff == CMD_REMOVE) ? ST_REM_SHIFT : ST_RESP;
            end else begin
               state_in = ST_BS_RD;
            end
         end
         ST_INS_SCAN: begin
            if ((pend_vld_ff && !cmp.lt) || up_end) begin
               state_in = ST_INS_SHIFT;
            end
         end
         ST_INS_SHIFT: begin
            if (dn_end) begin
               state_in = ST_RESP;
            end
         end
         ST_REM_SHIFT: begin
            if (up_end) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      sec_in       = sec_ff;
      ptr_in       = ptr_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      pos_in       = pos_ff;
      pend_vld_in  = 1'b0;
      pend_addr_in = pend_addr_ff;
      ok_in        = ok_ff;
      slot_in      = slot_ff;
      rsec_in      = rsec_ff;
      count_in     = count_ff;
      changed_in   = changed_ff;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff[IDX_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff;
      wr_data      = rd_data;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in  = req_data.cmd;
               key_in  = req_data.user_key[KEY_W-1:0];
               sec_in  = req_data.user_secret;
               ok_in   = 1'b0;
               slot_in = '0;
               rsec_in = '0;
               lo_in   = '0;
               hi_in   = count_ff;
               pos_in  = count_ff;
               // append goes straight to the write, nothing to shift
               ptr_in  = (req_data.cmd == CMD_INSERT && !ordered_mode) ? count_ff : '0;
            end
         end
         ST_SCAN: begin
            if (!hit && up_issue) begin
               rd_en        = 1'b1;
               ptr_in       = ptr_ff + CNT_W'(1);
               pend_vld_in  = 1'b1;
               pend_addr_in = ptr_ff[IDX_W-1:0];
            end
         end
         ST_BS_RD: begin
            if (lo_ff < hi_ff) begin
               rd_en   = 1'b1;
               rd_addr = mid_calc;
               mid_in  = mid_calc;
            end
         end
         ST_BS_CMP: begin
            if (cmp.lt) begin
               lo_in = CNT_W'(mid_ff) + CNT_W'(1);
            end else if (!cmp.eq) begin
               hi_in = CNT_W'(mid_ff);
            end
         end
         ST_INS_SCAN: begin
            // first slot whose key is not below the new key
            if (pend_vld_ff && !cmp.lt) begin
               pos_in = CNT_W'(pend_addr_ff);
               ptr_in = count_ff;
            end else if (up_end) begin
               pos_in = count_ff;
               ptr_in = count_ff;
            end else if (up_issue) begin
               rd_en        = 1'b1;
               ptr_in       = ptr_ff + CNT_W'(1);
               pend_vld_in  = 1'b1;
               pend_addr_in = ptr_ff[IDX_W-1:0];
            end
         end
         ST_INS_SHIFT: begin
            // move entries up one slot, top down, then place the new one
            if (pend_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_addr_ff + IDX_W'(1);
               wr_data = rd_data;
            end
            if (dn_issue) begin
               rd_en        = 1'b1;
               rd_addr      = IDX_W'(ptr_ff - CNT_W'(1));
               ptr_in       = ptr_ff - CNT_W'(1);
               pend_vld_in  = 1'b1;
               pend_addr_in = IDX_W'(ptr_ff - CNT_W'(1));
            end
            if (dn_end) begin
               wr_en      = 1'b1;
               wr_addr    = pos_ff[IDX_W-1:0];
               wr_data    = {key_ff, sec_ff};
               count_in   = count_ff + CNT_W'(1);
               changed_in = 1'b1;
               ok_in      = 1'b1;
            end
         end
         ST_REM_SHIFT: begin
            // move entries above the removed slot down one
            if (pend_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_addr_ff - IDX_W'(1);
               wr_data = rd_data;
            end
            if (up_issue) begin
               rd_en        = 1'b1;
               ptr_in       = ptr_ff + CNT_W'(1);
               pend_vld_in  = 1'b1;
               pend_addr_in = ptr_ff[IDX_W-1:0];
            end
            if (up_end) begin
               count_in   = count_ff - CNT_W'(1);
               changed_in = 1'b1;
               ok_in      = 1'b1;
            end
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase

      // match found by scan or halving search
      if (hit) begin
         unique case (cmd_ff)
            CMD_REMOVE: ptr_in = CNT_W'(hit_idx) + CNT_W'(1);
            CMD_LOOKUP: begin
               ok_in   = 1'b1;
               slot_in = SLOT_W'(hit_idx);
               rsec_in = rd_data[DATA_W-1:0];
            end
            CMD_VERIFY: ok_in = cmp.sec_eq;
            default:    ok_in = ok_ff;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pend_vld_ff <= 1'b0;
         count_ff    <= '0;
         changed_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pend_vld_ff <= pend_vld_in;
         count_ff    <= count_in;
         changed_ff  <= changed_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      sec_ff       <= sec_in;
      ptr_ff       <= ptr_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      pos_ff       <= pos_in;
      pend_addr_ff <= pend_addr_in;
      ok_ff        <= ok_in;
      slot_ff      <= slot_in;
      rsec_ff      <= rsec_in;
   end

   // outputs
   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = state_ff == ST_RESP;
   assign ref_key    = key_ff;
   assign ref_secret = sec_ff;

   always_comb begin
      rsp_data.ok            = ok_ff;
      rsp_data.slot_index    = slot_ff;
      rsp_data.stored_secret = rsec_ff;
      rsp_data.entries_held  = HELD_W'(count_ff);
      rsp_data.changed       = changed_ff;
   end

`ifndef SYNTHESIS
   a_resp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("result strobe not followed by idle");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> busy && !rsp_strobe)
      else $error("memory write outside command execution");

   a_count_sets_changed: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> changed_ff)
      else $error("entry count moved without changed flag");

   a_pend_from_read: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> $past(rd_en))
      else $error("pending read data without a read");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");
`endif

endmodule

/* sv/sorted_key_table_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_top: key and secret table, sorted or in arrival order
// Insert, remove, lookup and verify commands over a small entry memory.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken at a clock edge with start high and busy
//   low; busy stays high until its result has been shown. Each command gives
//   exactly one result, held on rsp_data for one cycle with rsp_strobe high.
//   The receiver cannot stall; the result is taken in that cycle.
//   csr_wdata sets ordered mode (1 sorted insert and halving search, 0 append
//   and linear scan); write it only while busy is low.
//   A command runs from its accept cycle to its strobe cycle, with at most one
//   memory read per cycle and registered data. A refused insert goes straight
//   to its result and an append writes the new entry directly; a sorted insert
//   scans for its slot, moves the entries above it up and then writes the new
//   one; a scan reads entries in turn until a hit; a halving search reads and
//   compares one probe at a time; a remove then moves the entries above the
//   removed slot down one. The single read port sets the pace of scans/shifts.
//   At CAPACITY 16 the slowest command is a sorted remove of slot 0 from a
//   full table; the next command can start the cycle after the strobe.
//   Reset clears the entry count, the changed flag and ordered mode; entry
//   contents are not cleared and only slots below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_key_table_top #(
   parameter int CAPACITY  = skt_pkg::CAPACITY_DEF,
   parameter int KEY_BYTES = skt_pkg::KEY_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  skt_pkg::req_type req_data,
   output logic             rsp_strobe,
   output skt_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_wdata
);
   import skt_pkg::*;

   localparam int KEY_W = KEY_BYTES * 8;
   localparam int ENT_W = KEY_W + DATA_W;
   localparam int IDX_W = $clog2(CAPACITY);

   logic              ordered_mode_ff, ordered_mode_in;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [ENT_W-1:0]  rd_data;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [ENT_W-1:0]  wr_data;
   logic [KEY_W-1:0]  ref_key;
   logic [DATA_W-1:0] ref_secret;
   cmp_res_type       cmp;

   // mode register write
   assign csr_ready = !busy;

   always_comb begin
      ordered_mode_in = ordered_mode_ff;
      if (csr_valid && csr_ready) begin
         ordered_mode_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ordered_mode_ff <= 1'b0;
      end else begin
         ordered_mode_ff <= ordered_mode_in;
      end
   end

   // command sequencer
   skt_seq #(
      .CAPACITY  (CAPACITY),
      .KEY_BYTES (KEY_BYTES)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .ordered_mode (ordered_mode_ff),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .cmp          (cmp),
      .ref_key      (ref_key),
      .ref_secret   (ref_secret),
      .rsp_strobe   (rsp_strobe),
      .rsp_data     (rsp_data)
   );

   // entry storage, key in the upper bits
   skt_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (ENT_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared comparator
   skt_cmp #(
      .KEY_W (KEY_W)
   ) u_cmp (
      .ent_key    (rd_data[ENT_W-1:DATA_W]),
      .ent_secret (rd_data[DATA_W-1:0]),
      .ref_key    (ref_key),
      .ref_secret (ref_secret),
      .res        (cmp)
   );

endmodule
